### src/dvfc_pkg.sv
// Shared field widths and stream layout for the distinct value frequency counter.
package dvfc_pkg;

   // Fixed widths of the element and result fields
   localparam int ELEM_W       = 32;
   localparam int OUT_VALUE_W  = 32;
   localparam int OUT_COUNT_W  = 7;

   // Result stream tdata: value, then count, padded to whole bytes
   localparam int RSP_DATA_RAW_W = OUT_VALUE_W + OUT_COUNT_W;
   localparam int RSP_DATA_W     = ((RSP_DATA_RAW_W + 7) / 8) * 8;

   // Width used to sign-extend a stored value before it is cut to the field
   localparam int SEXT_W = 64;

endpackage

### src/distinct_value_frequency_count.sv
// Distinct value frequency counter: first-occurrence table with per-value counts.
// Element: accepted while idle, then a table scan over the D distinct values held that
// issues one RAM read per cycle and ends early on a match; a dropped non-final element goes
// straight back to idle. No new element is accepted until the last one's scan has ended.
// Final element: after its scan, or at once if dropped, each result is read from the RAM
// and loaded when the output register frees; the next list is accepted once the last loads.
// Reset (synchronous, active high) clears the counters and flags; the table RAM is not
// cleared, since only entries below the distinct count are ever read.
module distinct_value_frequency_count
   import dvfc_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // Element stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ELEM_W-1:0]     req_tdata,   // [31:0] element_value
   input  logic                  req_tlast,   // final_element
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] distinct_value, [38:32] occurrence_count
   output logic                  rsp_tlast,   // run_end
   output logic                  rsp_tuser    // capacity_overflow
);

   localparam int IDX_W   = $clog2(MAX_ELEMENTS);
   localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
   localparam int ENTRY_W = VALUE_WIDTH + CNT_W;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      EMIT_RD,
      EMIT_LD
   } state_type;

   // Control registers
   state_type            state_ff,    state_in;
   logic [CNT_W-1:0]     distinct_ff, distinct_in;
   logic [CNT_W-1:0]     accepted_ff, accepted_in;
   logic                 dropped_ff,  dropped_in;
   logic [CNT_W-1:0]     issue_ff,    issue_in;
   logic                 cmp_vld_ff,  cmp_vld_in;
   logic                 rsp_vld_ff,  rsp_vld_in;

   // Payload registers
   logic [VALUE_WIDTH-1:0] elem_ff,     elem_in;
   logic                   last_ff,     last_in;
   logic [IDX_W-1:0]       cmp_idx_ff,  cmp_idx_in;
   logic [IDX_W-1:0]       emit_idx_ff, emit_idx_in;
   logic [OUT_VALUE_W-1:0] out_value_ff, out_value_in;
   logic [OUT_COUNT_W-1:0] out_count_ff, out_count_in;
   logic                   out_end_ff,  out_end_in;
   logic                   out_ovf_ff,  out_ovf_in;

   // Table RAM: {count, value} per entry
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   dvfc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   logic [VALUE_WIDTH-1:0]        rd_value;
   logic [CNT_W-1:0]              rd_count;
   logic signed [VALUE_WIDTH-1:0] rd_value_s;
   logic [SEXT_W-1:0]             rd_value_sext;
   logic                          hit;
   logic                          slot_free;
   logic                          run_last;

   assign rd_value      = ram_rd_data[VALUE_WIDTH-1:0];
   assign rd_count      = ram_rd_data[ENTRY_W-1:VALUE_WIDTH];
   assign rd_value_s    = signed'(rd_value);
   assign rd_value_sext = SEXT_W'(rd_value_s);

   // A compare is live in the cycle after its read was issued
   assign hit       = cmp_vld_ff && (rd_value == elem_ff);
   // The result register can take a new transfer
   assign slot_free = !rsp_vld_ff || rsp_tready;
   assign run_last  = (CNT_W'(emit_idx_ff) + 1'b1) == distinct_ff;

   assign req_tready = (state_ff == IDLE);

   always_comb begin
      state_in     = state_ff;
      distinct_in  = distinct_ff;
      accepted_in  = accepted_ff;
      dropped_in   = dropped_ff;
      issue_in     = issue_ff;
      cmp_vld_in   = 1'b0;
      elem_in      = elem_ff;
      last_in      = last_ff;
      cmp_idx_in   = cmp_idx_ff;
      emit_idx_in  = emit_idx_ff;
      out_value_in = out_value_ff;
      out_count_in = out_count_ff;
      out_end_in   = out_end_ff;
      out_ovf_in   = out_ovf_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = cmp_idx_ff;
      ram_wr_data  = {rd_count, elem_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = issue_ff[IDX_W-1:0];

      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               elem_in     = VALUE_WIDTH'(req_tdata);
               last_in     = req_tlast;
               emit_idx_in = '0;
               if (accepted_ff == CNT_W'(MAX_ELEMENTS)) begin
                  // Table full: drop the element, still close the list on final
                  dropped_in = 1'b1;
                  state_in   = req_tlast ? EMIT_RD : IDLE;
               end else begin
                  accepted_in = accepted_ff + 1'b1;
                  issue_in    = '0;
                  state_in    = SCAN;
               end
            end
         end

         SCAN: begin
            // Issue one read per cycle until every held entry is in flight
            if (issue_ff != distinct_ff) begin
               ram_rd_en  = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + 1'b1;
            end
            if (hit) begin
               // Known value: bump its count
               ram_wr_en   = 1'b1;
               ram_wr_addr = cmp_idx_ff;
               ram_wr_data = {CNT_W'(rd_count + 1'b1), elem_ff};
               cmp_vld_in  = 1'b0;
               state_in    = last_ff ? EMIT_RD : IDLE;
            end else if (issue_ff == distinct_ff) begin
               // Every entry compared without a match: append a new one
               ram_wr_en   = 1'b1;
               ram_wr_addr = distinct_ff[IDX_W-1:0];
               ram_wr_data = {CNT_W'(1), elem_ff};
               distinct_in = distinct_ff + 1'b1;
               cmp_vld_in  = 1'b0;
               state_in    = last_ff ? EMIT_RD : IDLE;
            end
         end

         EMIT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = emit_idx_ff;
            state_in    = EMIT_LD;
         end

         EMIT_LD: begin
            // Hold the read data until the result register frees up
            if (slot_free) begin
               rsp_vld_in   = 1'b1;
               out_value_in = rd_value_sext[OUT_VALUE_W-1:0];
               out_count_in = OUT_COUNT_W'(rd_count);
               out_end_in   = run_last;
               out_ovf_in   = dropped_ff;
               if (run_last) begin
                  // Run complete: clear the list for the next one
                  distinct_in = '0;
                  accepted_in = '0;
                  dropped_in  = 1'b0;
                  state_in    = IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
                  state_in    = EMIT_RD;
               end
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         distinct_ff <= '0;
         accepted_ff <= '0;
         dropped_ff  <= 1'b0;
         issue_ff    <= '0;
         cmp_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         distinct_ff <= distinct_in;
         accepted_ff <= accepted_in;
         dropped_ff  <= dropped_in;
         issue_ff    <= issue_in;
         cmp_vld_ff  <= cmp_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      elem_ff      <= elem_in;
      last_ff      <= last_in;
      cmp_idx_ff   <= cmp_idx_in;
      emit_idx_ff  <= emit_idx_in;
      out_value_ff <= out_value_in;
      out_count_ff <= out_count_in;
      out_end_ff   <= out_end_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_count_ff, out_value_ff});
   assign rsp_tlast  = out_end_ff;
   assign rsp_tuser  = out_ovf_ff;

endmodule

### src/dvfc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module dvfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/frequency_run_checker.sv
// Checker for the distinct value frequency counter: tallies elements and compares results.
module frequency_run_checker
   import dvfc_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [ELEM_W-1:0]     req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  rsp_tuser,
   output int                    error_count,
   output int                    tallies_pending,
   output int                    tallies_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;

   typedef struct {
      logic [OUT_VALUE_W-1:0] value;
      logic [OUT_COUNT_W-1:0] count;
      logic                   run_end;
      logic                   overflow;
   } tally_type;

   logic [VALUE_WIDTH-1:0] seen_value [TABLE_DEPTH];
   logic [OUT_COUNT_W-1:0] seen_count [TABLE_DEPTH];
   int                     distinct_held  = 0;
   int                     elements_taken = 0;
   bit                     list_dropped   = 1'b0;
   tally_type              expected_tally_q [$];
   int                     errors  = 0;
   int                     checked = 0;

   // Count one element into the first-occurrence table, or mark the list dropped when full; on
   // the final element, queue one tally per distinct value and clear the table.
   task automatic tally_element(input logic [ELEM_W-1:0] element, input logic final_flag);
      logic [VALUE_WIDTH-1:0] key;
      logic [SEXT_W-1:0]      wide;
      tally_type              entry;
      int                     slot;
      bit                     found;
      key = VALUE_WIDTH'(element);
      if (elements_taken < MAX_ELEMENTS && elements_taken < TABLE_DEPTH) begin
         found = 1'b0;
         for (slot = 0; slot < distinct_held; slot++) begin
            if (!found && seen_value[slot] == key) begin
               seen_count[slot] = seen_count[slot] + 1'b1;
               found = 1'b1;
            end
         end
         if (!found && distinct_held < TABLE_DEPTH) begin
            seen_value[distinct_held] = key;
            seen_count[distinct_held] = OUT_COUNT_W'(1);
            distinct_held++;
         end
         elements_taken++;
      end else begin
         list_dropped = 1'b1;
      end
      if (final_flag) begin
         for (slot = 0; slot < distinct_held; slot++) begin
            wide           = SEXT_W'(signed'(seen_value[slot]));
            entry.value    = wide[OUT_VALUE_W-1:0];
            entry.count    = seen_count[slot];
            entry.run_end  = (slot == distinct_held - 1);
            entry.overflow = list_dropped;
            expected_tally_q.push_back(entry);
         end
         distinct_held  = 0;
         elements_taken = 0;
         list_dropped   = 1'b0;
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      tally_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tally_q.size() == 0) begin
               errors++;
               $display("%0t: result with none expected: expected nothing, actual %h/%0d/%b/%b",
                        $time, rsp_tdata[OUT_VALUE_W-1:0],
                        rsp_tdata[OUT_VALUE_W +: OUT_COUNT_W], rsp_tlast, rsp_tuser);
            end else begin
               want = expected_tally_q.pop_front();
               compare_field("distinct_value", want.value, rsp_tdata[OUT_VALUE_W-1:0]);
               compare_field("occurrence_count", 32'(want.count),
                             32'(rsp_tdata[OUT_VALUE_W +: OUT_COUNT_W]));
               compare_field("run_end", 32'(want.run_end), 32'(rsp_tlast));
               compare_field("capacity_overflow", 32'(want.overflow), 32'(rsp_tuser));
               checked++;
            end
         end
         if (req_tvalid && req_tready)
            tally_element(req_tdata, req_tlast);
      end
      error_count     <= errors;
      tallies_pending <= expected_tally_q.size();
      tallies_checked <= checked;
   end

endmodule

### tb/tb_distinct_value_frequency_count.sv
// Testbench top for the distinct value frequency counter: stimulus, stalls and verdict.
module tb_distinct_value_frequency_count;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any transfer before the run is declared hung: covers the long
   // receiver hold-off, a full 64-entry scan and the widest random gaps, several times.
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 150;
   localparam int ITEM_TARGET  = 380;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [dvfc_pkg::ELEM_W-1:0]    req_tdata = '0;   // [31:0] element_value
   logic                           req_tlast = 1'b0; // final_element
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [dvfc_pkg::RSP_DATA_W-1:0] rsp_tdata;       // [31:0] value, [38:32] count
   logic                           rsp_tlast;        // run_end
   logic                           rsp_tuser;        // capacity_overflow

   int error_count;
   int tallies_pending;
   int tallies_checked;

   // Stimulus bookkeeping and the knobs shared with the receiver process
   int items_sent     = 0;
   int lists_sent     = 0;
   int overflow_lists = 0;
   bit quiet          = 0;   // no random idling on either side while set
   int hold_ticket    = 0;   // bump to ask the receiver for one long hold-off
   int hold_served    = 0;
   int stall_cycles   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   distinct_value_frequency_count DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   frequency_run_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser),
      .error_count     (error_count),
      .tallies_pending (tallies_pending),
      .tallies_checked (tallies_checked)
   );

   // Receiver: drop tready about 15% of cycles, hold it high while quiet,
   // and serve a requested hold-off by counting cycles here.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (quiet || $urandom_range(99) >= 15) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
         end
      end
   end

   // Watchdog: end the run if no transfer happens on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offer one element, maybe after a random gap, and hold it until the transfer.
   // Valid stays high on return so the next element follows without a bubble.
   task automatic push_element(input logic [31:0] value, input logic last);
      if (!quiet && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tdata  <= value;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (last)
         lists_sent++;
   endtask

   // Stop offering and wait until every queued result has been checked.
   // The extra edges let the checker's count catch up with the last transfer.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (tallies_pending != 0) @(posedge clock);
   endtask

   // Send one list whose elements are drawn from a small random pool, so values repeat
   task automatic send_pool_list(input int length, input int pool_size);
      logic [31:0] pool [64];
      int          k;
      for (k = 0; k < pool_size; k++)
         pool[k] = $urandom;
      for (k = 0; k < length; k++)
         push_element(pool[$urandom_range(0, pool_size - 1)], k == length - 1);
   endtask

   initial begin
      int          k;
      int          length;
      logic [31:0] value;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, repeats, single-element list, final value repeating
      push_element(32'h8000_0000, 1'b1);
      push_element(32'h7FFF_FFFF, 1'b0);
      push_element(32'h7FFF_FFFF, 1'b0);
      push_element(32'hFFFF_FFFF, 1'b0);
      push_element(32'h0000_0000, 1'b0);
      push_element(32'hFFFF_FFFF, 1'b1);
      push_element(32'hAAAA_AAAA, 1'b0);
      push_element(32'h5555_5555, 1'b0);
      push_element(32'hAAAA_AAAA, 1'b1);
      push_element(32'h1234_5678, 1'b0);
      push_element(32'h1234_5678, 1'b1);
      drain_results();

      // Back-pressure: hold the receiver off while two lists are offered,
      // so the second one stalls behind the pending run
      hold_ticket <= hold_ticket + 1;
      send_pool_list(4, 2);
      send_pool_list(6, 3);
      drain_results();

      // Steady stretch with no idling on either side
      quiet <= 1'b1;
      while (items_sent < 90)
         send_pool_list($urandom_range(1, 12), $urandom_range(1, 4));
      quiet <= 1'b0;

      // Capacity: 64 distinct values plus two dropped elements, the final one among them
      for (k = 0; k < 64; k++)
         push_element(($urandom & 32'hFFFF_FFC0) | 32'(k), 1'b0);
      push_element($urandom, 1'b0);
      push_element($urandom, 1'b1);
      overflow_lists++;
      drain_results();

      // Exactly at capacity: 64 elements, no drop
      send_pool_list(64, 3);

      // One value 65 times: count saturates the table at 64, final element dropped
      value = $urandom;
      for (k = 0; k < 65; k++)
         push_element(value, k == 64);
      overflow_lists++;
      drain_results();

      // Random lists, mostly short, now and then longer
      while (items_sent < ITEM_TARGET) begin
         length = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         send_pool_list(length, $urandom_range(1, length));
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d elements in %0d lists, %0d of them past table capacity.",
               items_sent, lists_sent, overflow_lists);
      $display("Checked %0d frequency results, including receiver hold-off and idle gaps.",
               tallies_checked);
      if (error_count == 0 && tallies_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
